[rtl/rrbd_pkg.sv]
// ----------------------------------------------------------------------------
// rrbd_pkg
// Shared types and constants of the request rate burst detector.
// ----------------------------------------------------------------------------
`default_nettype none

package rrbd_pkg;

  localparam int unsigned CodeW     = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned WinW      = 16;
  localparam int unsigned IdThrW    = 4;
  localparam int unsigned BurstThrW = 7;
  localparam int unsigned CntOutW   = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ID_WINDOW       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ID_THRESHOLD    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALERT_HOLDOFF   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BURST_WINDOW    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BURST_THRESHOLD = 3'd4;

  // reset values of the configuration registers
  localparam logic [WinW-1:0]      RST_ID_WINDOW       = 16'd400;
  localparam logic [IdThrW-1:0]    RST_ID_THRESHOLD    = 4'd4;
  localparam logic [WinW-1:0]      RST_ALERT_HOLDOFF   = 16'd600;
  localparam logic [WinW-1:0]      RST_BURST_WINDOW    = 16'd40;
  localparam logic [BurstThrW-1:0] RST_BURST_THRESHOLD = 7'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_TIMES,
    ST_ALERT,
    ST_RSCAN,
    ST_BURST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [WinW-1:0]      id_window;
    logic [IdThrW-1:0]    id_threshold;
    logic [WinW-1:0]      alert_holdoff;
    logic [WinW-1:0]      burst_window;
    logic [BurstThrW-1:0] burst_threshold;
  } cfg_t;

  // packed from the top bit down, so alert lands in bit 0 of tdata
  typedef struct packed {
    logic [TimeW-1:0]     code_total;
    logic [BurstThrW-1:0] burst_count;
    logic                 burst_alert;
    logic [WinW-1:0]      same_code_span;
    logic [CntOutW-1:0]   same_code_count;
    logic                 same_code_alert;
  } res_t;

endpackage

`default_nettype wire

[rtl/rrbd_ram.sv]
// ----------------------------------------------------------------------------
// rrbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/rrbd_age_unit.sv]
// ----------------------------------------------------------------------------
// rrbd_age_unit
// Shared wrapped age subtractor with window and holdoff compares.
// ----------------------------------------------------------------------------
`default_nettype none

module rrbd_age_unit (
  input  wire logic [rrbd_pkg::TimeW-1:0] now_i,
  input  wire logic [rrbd_pkg::TimeW-1:0] then_i,
  input  wire logic [rrbd_pkg::WinW-1:0]  window_i,
  input  wire logic [rrbd_pkg::WinW-1:0]  holdoff_i,
  output logic      [rrbd_pkg::TimeW-1:0] age_o,
  output logic                            in_window_o,
  output logic                            holdoff_met_o
);
  import rrbd_pkg::*;

  // age wraps modulo 2^32
  assign age_o         = now_i - then_i;
  assign in_window_o   = age_o <= TimeW'(window_i);
  assign holdoff_met_o = age_o >= TimeW'(holdoff_i);

endmodule

`default_nettype wire

[rtl/rrbd_ctrl.sv]
// ----------------------------------------------------------------------------
// rrbd_ctrl
// Sequencer, table/ring memories and datapath around the shared age unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rrbd_ctrl #(
  parameter int unsigned TABLE_ENTRIES   = 128,
  parameter int unsigned TIMES_PER_ENTRY = 8,
  parameter int unsigned RECENT_DEPTH    = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [rrbd_pkg::CodeW-1:0]      code_i,
  input  wire logic [rrbd_pkg::TimeW-1:0]      now_i,
  input  wire rrbd_pkg::cfg_t                  cfg_i,
  output logic                                 ready_o,
  output logic                                 res_valid_o,
  input  wire logic                            res_ready_i,
  output rrbd_pkg::res_t                       res_o
);
  import rrbd_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned NUW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned FW   = $clog2(TIMES_PER_ENTRY + 1);
  localparam int unsigned PW   = (TIMES_PER_ENTRY > 1) ? $clog2(TIMES_PER_ENTRY) : 1;
  localparam int unsigned TDEP = TABLE_ENTRIES * TIMES_PER_ENTRY;
  localparam int unsigned TAW  = $clog2(TDEP);
  localparam int unsigned RPW  = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam int unsigned RFW  = $clog2(RECENT_DEPTH + 1);
  localparam int unsigned RECW = CodeW + 4 * TimeW + FW + PW;

  state_e state_q, state_d;

  // request
  logic [CodeW-1:0] code_q;
  logic [TimeW-1:0] now_q;

  // table scan
  logic [NUW-1:0]   num_used_q;
  logic [NUW-1:0]   sidx_q;
  logic             spend_q;
  logic [AW-1:0]    sp_idx_q;
  logic [AW-1:0]    vic_q;
  logic [TimeW-1:0] vic_ls_q;
  logic [AW-1:0]    e_q;

  // working copy of the entry record
  logic [TimeW-1:0] r_total_q, r_last_alert_q, r_alert_cnt_q;
  logic [FW-1:0]    r_fill_q;
  logic [PW-1:0]    r_ptr_q;

  // entry time scan
  logic [TAW-1:0]   tbase_q;
  logic [FW-1:0]    tidx_q;
  logic             tpend_q;
  logic [FW-1:0]    cnt_q;
  logic [WinW-1:0]  span_q;
  logic             same_alert_q;

  // global recent ring
  logic [RPW-1:0]   rptr_q, rslot_q;
  logic [RFW-1:0]   rfill_q, ridx_q, rcnt_q;
  logic             rpend_q;
  logic [TimeW-1:0] blast_q;
  logic             burst_q;

  // memories
  logic            rec_we;
  logic [AW-1:0]   rec_raddr;
  logic [RECW-1:0] rec_wdata, rec_rdata;
  logic            tim_we;
  logic [TAW-1:0]  tim_waddr, tim_raddr;
  logic [TimeW-1:0] tim_rdata;
  logic            rct_we;
  logic [RPW-1:0]  rct_raddr;
  logic [TimeW-1:0] rct_rdata;

  // shared age unit
  logic [TimeW-1:0] age_then, age;
  logic [WinW-1:0]  age_win;
  logic             in_win, hold_met;

  // decoded control
  logic [CodeW-1:0] rd_code;
  logic [TimeW-1:0] rd_ls, rd_total, rd_la, rd_ac;
  logic [FW-1:0]    rd_fill;
  logic [PW-1:0]    rd_ptr;
  logic             scan_hit, scan_issue, scan_end;
  logic             t_issue, t_end;
  logic             r_stop, r_issue, r_end;
  logic             id_fire, b_fire;
  logic [TAW-1:0]   ebase;
  logic [PW-1:0]    ptr_next;
  logic [RPW-1:0]   rptr_next;

  assign {rd_code, rd_ls, rd_total, rd_la, rd_ac, rd_fill, rd_ptr} = rec_rdata;

  rrbd_ram #(.WIDTH(RECW), .DEPTH(TABLE_ENTRIES)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (e_q),
    .wdata_i (rec_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  rrbd_ram #(.WIDTH(TimeW), .DEPTH(TDEP)) u_times_ram (
    .clk_i   (clk_i),
    .we_i    (tim_we),
    .waddr_i (tim_waddr),
    .wdata_i (now_q),
    .raddr_i (tim_raddr),
    .rdata_o (tim_rdata)
  );

  rrbd_ram #(.WIDTH(TimeW), .DEPTH(RECENT_DEPTH)) u_recent_ram (
    .clk_i   (clk_i),
    .we_i    (rct_we),
    .waddr_i (rptr_q),
    .wdata_i (now_q),
    .raddr_i (rct_raddr),
    .rdata_o (rct_rdata)
  );

  rrbd_age_unit u_age (
    .now_i         (now_q),
    .then_i        (age_then),
    .window_i      (age_win),
    .holdoff_i     (cfg_i.alert_holdoff),
    .age_o         (age),
    .in_window_o   (in_win),
    .holdoff_met_o (hold_met)
  );

  // per-step conditions
  assign scan_hit   = (state_q == ST_SCAN) && spend_q && (rd_code == code_q);
  assign scan_issue = (state_q == ST_SCAN) && !scan_hit && (sidx_q < num_used_q);
  assign scan_end   = !spend_q && !(sidx_q < num_used_q);
  assign t_issue    = tidx_q < r_fill_q;
  assign t_end      = !tpend_q && !t_issue;
  assign r_stop     = rpend_q && !in_win;
  assign r_issue    = !r_stop && (ridx_q < rfill_q);
  assign r_end      = r_stop || (!rpend_q && !r_issue);
  assign id_fire    = (32'(cnt_q) >= 32'(cfg_i.id_threshold)) &&
                      ((r_alert_cnt_q == '0) || hold_met);
  assign b_fire     = (32'(rcnt_q) >= 32'(cfg_i.burst_threshold)) &&
                      ((blast_q == '0) || hold_met);
  assign ebase      = TAW'(e_q) * TAW'(TIMES_PER_ENTRY);
  assign ptr_next   = (r_ptr_q == PW'(TIMES_PER_ENTRY - 1)) ? '0 : r_ptr_q + 1'b1;
  assign rptr_next  = (rptr_q == RPW'(RECENT_DEPTH - 1)) ? '0 : rptr_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_SCAN;
      ST_SCAN:   if (scan_hit || scan_end) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_TIMES;
      ST_TIMES:  if (t_end) state_d = ST_ALERT;
      ST_ALERT:  state_d = ST_RSCAN;
      ST_RSCAN:  if (r_end) state_d = ST_BURST;
      ST_BURST:  state_d = ST_DONE;
      ST_DONE:   if (res_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs, memory ports and age operands
  always_comb begin
    ready_o     = 1'b0;
    res_valid_o = 1'b0;
    rec_we      = 1'b0;
    rec_raddr   = sidx_q[AW-1:0];
    rec_wdata   = {code_q, now_q, r_total_q,
                   id_fire ? now_q : r_last_alert_q,
                   id_fire ? r_alert_cnt_q + 1'b1 : r_alert_cnt_q,
                   r_fill_q, r_ptr_q};
    tim_we      = 1'b0;
    tim_waddr   = ebase + TAW'(r_ptr_q);
    tim_raddr   = tbase_q + TAW'(tidx_q);
    rct_we      = 1'b0;
    rct_raddr   = rslot_q;
    age_then    = '0;
    age_win     = cfg_i.id_window;
    unique case (state_q)
      ST_IDLE:   ready_o = 1'b1;
      ST_SCAN:   ;
      ST_UPDATE: tim_we = 1'b1;
      ST_TIMES:  age_then = tim_rdata;
      ST_ALERT: begin
        age_then = r_last_alert_q;
        rec_we   = 1'b1;
        rct_we   = 1'b1;
      end
      ST_RSCAN: begin
        age_then = rct_rdata;
        age_win  = cfg_i.burst_window;
      end
      ST_BURST:  age_then = blast_q;
      ST_DONE:   res_valid_o = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_used_q <= '0;
      sidx_q     <= '0;
      spend_q    <= 1'b0;
      tidx_q     <= '0;
      tpend_q    <= 1'b0;
      rptr_q     <= '0;
      rfill_q    <= '0;
      rslot_q    <= '0;
      ridx_q     <= '0;
      rpend_q    <= 1'b0;
      blast_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          sidx_q  <= '0;
          spend_q <= 1'b0;
        end
        ST_SCAN: begin
          spend_q <= scan_issue;
          if (scan_issue) sidx_q <= sidx_q + 1'b1;
          if (!scan_hit && scan_end && (num_used_q < NUW'(TABLE_ENTRIES))) begin
            num_used_q <= num_used_q + 1'b1;
          end
        end
        ST_UPDATE: begin
          tidx_q  <= '0;
          tpend_q <= 1'b0;
        end
        ST_TIMES: begin
          tpend_q <= t_issue;
          if (t_issue) tidx_q <= tidx_q + 1'b1;
        end
        ST_ALERT: begin
          rslot_q <= rptr_q;
          rptr_q  <= rptr_next;
          if (rfill_q != RFW'(RECENT_DEPTH)) rfill_q <= rfill_q + 1'b1;
          ridx_q  <= '0;
          rpend_q <= 1'b0;
        end
        ST_RSCAN: begin
          rpend_q <= r_issue;
          if (r_issue) begin
            ridx_q  <= ridx_q + 1'b1;
            rslot_q <= (rslot_q == '0) ? RPW'(RECENT_DEPTH - 1) : rslot_q - 1'b1;
          end
        end
        ST_BURST: if (b_fire) blast_q <= now_q;
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  // payload datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          code_q <= code_i;
          now_q  <= now_i;
        end
      end
      ST_SCAN: begin
        sp_idx_q <= sidx_q[AW-1:0];
        // least recently seen, lowest index on a tie
        if (spend_q && !scan_hit && ((sp_idx_q == '0) || (rd_ls < vic_ls_q))) begin
          vic_q    <= sp_idx_q;
          vic_ls_q <= rd_ls;
        end
        if (scan_hit) begin
          e_q            <= sp_idx_q;
          r_total_q      <= rd_total;
          r_last_alert_q <= rd_la;
          r_alert_cnt_q  <= rd_ac;
          r_fill_q       <= rd_fill;
          r_ptr_q        <= rd_ptr;
        end else if (scan_end) begin
          e_q            <= (num_used_q < NUW'(TABLE_ENTRIES)) ? num_used_q[AW-1:0] : vic_q;
          r_total_q      <= '0;
          r_last_alert_q <= '0;
          r_alert_cnt_q  <= '0;
          r_fill_q       <= '0;
          r_ptr_q        <= '0;
        end
      end
      ST_UPDATE: begin
        r_total_q <= r_total_q + 1'b1;
        r_ptr_q   <= ptr_next;
        if (r_fill_q != FW'(TIMES_PER_ENTRY)) r_fill_q <= r_fill_q + 1'b1;
        tbase_q   <= ebase;
        cnt_q     <= '0;
        span_q    <= '0;
      end
      ST_TIMES: begin
        if (tpend_q && in_win) begin
          cnt_q <= cnt_q + 1'b1;
          if (age[WinW-1:0] > span_q) span_q <= age[WinW-1:0];
        end
      end
      ST_ALERT: begin
        same_alert_q <= id_fire;
        rcnt_q       <= '0;
      end
      ST_RSCAN: if (rpend_q && in_win) rcnt_q <= rcnt_q + 1'b1;
      ST_BURST: burst_q <= b_fire;
      ST_DONE: ;
      default: ;
    endcase
  end

  assign res_o.same_code_alert = same_alert_q;
  assign res_o.same_code_count = CntOutW'(cnt_q);
  assign res_o.same_code_span  = span_q;
  assign res_o.burst_alert     = burst_q;
  assign res_o.burst_count     = BurstThrW'(rcnt_q);
  assign res_o.code_total      = r_total_q;

endmodule

`default_nettype wire

[rtl/request_rate_burst_detector.sv]
// ----------------------------------------------------------------------------
// request_rate_burst_detector
// Per-identifier and global request burst detection for sound requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transfer: tdata[15:0] sound_code,
//   tdata[47:16] frame_time. m_axis returns exactly one result per request.
//   The cfg channel writes the five threshold/window registers (index 0..4);
//   it is always ready; the user must write it only while the block is idle,
//   which the block itself does not enforce.
// Work per request:
//   A request walks U table entries (up to TABLE_ENTRIES, one record RAM
//   read per cycle), F stored times of its entry (up to TIMES_PER_ENTRY)
//   and R recent ring slots (up to RECENT_DEPTH), all through the one shared
//   age unit. The next request is accepted only after the result of the
//   last one has been handed to the output register.
//   s_axis_tready is low while a request is in work.
// Reset:
//   Clears the table fill count, the recent ring and the burst alert frame;
//   registers return to their defaults. No clearing pass is needed.
// Stall:
//   A result waits in the output register; the next request is accepted
//   meanwhile and its result is held in the sequencer until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module request_rate_burst_detector #(
  parameter int unsigned TABLE_ENTRIES   = 128,
  parameter int unsigned TIMES_PER_ENTRY = 8,
  parameter int unsigned RECENT_DEPTH    = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // sound_code[15:0], frame_time[47:16]
  input  wire logic [rrbd_pkg::InDataW-1:0]      s_axis_tdata,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // same_code_alert[0], same_code_count[4:1], same_code_span[20:5],
  // burst_alert[21], burst_count[28:22], code_total[60:29], zero[63:61]
  output logic      [rrbd_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [rrbd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [rrbd_pkg::CfgDataW-1:0]     cfg_data_i
);
  import rrbd_pkg::*;

  cfg_t cfg_q;
  res_t res, out_q;
  logic out_valid_q;
  logic start, res_valid, res_ready;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.id_window       <= RST_ID_WINDOW;
      cfg_q.id_threshold    <= RST_ID_THRESHOLD;
      cfg_q.alert_holdoff   <= RST_ALERT_HOLDOFF;
      cfg_q.burst_window    <= RST_BURST_WINDOW;
      cfg_q.burst_threshold <= RST_BURST_THRESHOLD;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ID_WINDOW:       cfg_q.id_window       <= cfg_data_i;
        CFG_ID_THRESHOLD:    cfg_q.id_threshold    <= cfg_data_i[IdThrW-1:0];
        CFG_ALERT_HOLDOFF:   cfg_q.alert_holdoff   <= cfg_data_i;
        CFG_BURST_WINDOW:    cfg_q.burst_window    <= cfg_data_i;
        CFG_BURST_THRESHOLD: cfg_q.burst_threshold <= cfg_data_i[BurstThrW-1:0];
        default: ;
      endcase
    end
  end

  assign start = s_axis_tvalid && s_axis_tready;

  rrbd_ctrl #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .TIMES_PER_ENTRY (TIMES_PER_ENTRY),
    .RECENT_DEPTH    (RECENT_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .code_i      (s_axis_tdata[CodeW-1:0]),
    .now_i       (s_axis_tdata[CodeW +: TimeW]),
    .cfg_i       (cfg_q),
    .ready_o     (s_axis_tready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_q);

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a request is in work");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |=> m_axis_tvalid)
    else $error("finished result not presented");

  a_count_has_now: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[4:1] != 4'd0)
    else $error("same code count misses the current request");

endmodule

`default_nettype wire

[test/rrbd_checker.sv]
// ----------------------------------------------------------------------------
// rrbd_checker
// Watches the request, result and register channels of the burst detector,
// keeps its own copy of the identifier table, the recent-request ring and the
// registers, predicts one result per accepted request and compares it field
// by field with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module rrbd_checker
  import rrbd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [InDataW-1:0]  req_tdata_i,
  input  wire logic                req_tvalid_i,
  input  wire logic                req_tready_i,
  input  wire logic [OutDataW-1:0] res_tdata_i,
  input  wire logic                res_tvalid_i,
  input  wire logic                res_tready_i,
  input  wire logic                cfg_valid_i,
  input  wire logic                cfg_ready_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumEntries = 128;
  localparam int TimesPerEntry = 8;
  localparam int RecentDepth = 64;

  // register copy
  cfg_t regs;

  // identifier table
  logic              used_q      [NumEntries];
  logic [CodeW-1:0]  code_q      [NumEntries];
  logic [TimeW-1:0]  seen_q      [NumEntries];
  logic [TimeW-1:0]  total_q     [NumEntries];
  logic [TimeW-1:0]  alerted_q   [NumEntries];
  logic [TimeW-1:0]  n_alerts_q  [NumEntries];
  logic [TimeW-1:0]  hist_q      [NumEntries][TimesPerEntry];
  int unsigned       hist_fill_q [NumEntries];
  int unsigned       hist_ptr_q  [NumEntries];

  // global ring of request frames
  logic [TimeW-1:0]  ring_q [RecentDepth];
  int unsigned       ring_fill_q;
  int unsigned       ring_ptr_q;
  logic [TimeW-1:0]  burst_alerted_q;

  res_t expected_results[$];
  int   mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_results.size();

  // Returns the entry of a code, allocating or evicting as needed.
  function automatic int lookup_code(logic [CodeW-1:0] code);
    int victim;
    victim = 0;
    for (int i = 0; i < NumEntries; i++) begin
      if (used_q[i] && code_q[i] == code) return i;
      if (!used_q[i]) begin
        victim = i;
        break;
      end
      if (seen_q[i] < seen_q[victim]) victim = i;
    end
    used_q[victim]      = 1'b1;
    code_q[victim]      = code;
    seen_q[victim]      = '0;
    total_q[victim]     = '0;
    alerted_q[victim]   = '0;
    n_alerts_q[victim]  = '0;
    for (int k = 0; k < TimesPerEntry; k++) hist_q[victim][k] = '0;
    hist_fill_q[victim] = 0;
    hist_ptr_q[victim]  = 0;
    return victim;
  endfunction

  // Advances the model by one request and returns its result.
  function automatic res_t detect_request(logic [CodeW-1:0] code, logic [TimeW-1:0] now);
    res_t r;
    int e;
    int unsigned hits, recent;
    logic [TimeW-1:0] age, span;
    ring_q[ring_ptr_q] = now;
    ring_ptr_q = (ring_ptr_q + 1) % RecentDepth;
    if (ring_fill_q < RecentDepth) ring_fill_q++;

    e = lookup_code(code);
    total_q[e] = total_q[e] + 1;
    seen_q[e] = now;
    hist_q[e][hist_ptr_q[e]] = now;
    hist_ptr_q[e] = (hist_ptr_q[e] + 1) % TimesPerEntry;
    if (hist_fill_q[e] < TimesPerEntry) hist_fill_q[e]++;
    hits = 0;
    span = '0;
    for (int i = 0; i < hist_fill_q[e]; i++) begin
      age = now - hist_q[e][i];
      if (age <= TimeW'(regs.id_window)) begin
        hits++;
        if (age > span) span = age;
      end
    end
    r = '0;
    if (hits >= regs.id_threshold &&
        (n_alerts_q[e] == 0 || now - alerted_q[e] >= TimeW'(regs.alert_holdoff))) begin
      n_alerts_q[e] = n_alerts_q[e] + 1;
      alerted_q[e] = now;
      r.same_code_alert = 1'b1;
    end

    // newest consecutive requests inside the burst window
    recent = 0;
    for (int i = 0; i < ring_fill_q; i++) begin
      if (now - ring_q[(ring_ptr_q + RecentDepth - 1 - i) % RecentDepth]
          <= TimeW'(regs.burst_window)) recent++;
      else break;
    end
    if (recent >= regs.burst_threshold &&
        (burst_alerted_q == 0 || now - burst_alerted_q >= TimeW'(regs.alert_holdoff))) begin
      burst_alerted_q = now;
      r.burst_alert = 1'b1;
    end
    r.same_code_count = hits[CntOutW-1:0];
    r.same_code_span  = span[WinW-1:0];
    r.burst_count     = recent[BurstThrW-1:0];
    r.code_total      = total_q[e];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      regs.id_window       <= RST_ID_WINDOW;
      regs.id_threshold    <= RST_ID_THRESHOLD;
      regs.alert_holdoff   <= RST_ALERT_HOLDOFF;
      regs.burst_window    <= RST_BURST_WINDOW;
      regs.burst_threshold <= RST_BURST_THRESHOLD;
      for (int i = 0; i < NumEntries; i++) used_q[i] = 1'b0;
      ring_fill_q     = 0;
      ring_ptr_q      = 0;
      burst_alerted_q = '0;
      mismatches      = 0;
      expected_results.delete();
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ID_WINDOW:       regs.id_window       <= cfg_data_i;
          CFG_ID_THRESHOLD:    regs.id_threshold    <= cfg_data_i[IdThrW-1:0];
          CFG_ALERT_HOLDOFF:   regs.alert_holdoff   <= cfg_data_i;
          CFG_BURST_WINDOW:    regs.burst_window    <= cfg_data_i;
          CFG_BURST_THRESHOLD: regs.burst_threshold <= cfg_data_i[BurstThrW-1:0];
          default: ;
        endcase
      end
      // request transfer
      if (req_tvalid_i && req_tready_i)
        expected_results.push_back(detect_request(req_tdata_i[CodeW-1:0],
                                                  req_tdata_i[CodeW +: TimeW]));
      // result transfer
      if (res_tvalid_i && res_tready_i) begin
        got = res_t'(res_tdata_i[$bits(res_t)-1:0]);
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("[%0t] unexpected result %h", $realtime, got);
        end else begin
          want = expected_results.pop_front();
          if (got.same_code_alert !== want.same_code_alert ||
              got.same_code_count !== want.same_code_count ||
              got.same_code_span  !== want.same_code_span  ||
              got.burst_alert     !== want.burst_alert     ||
              got.burst_count     !== want.burst_count     ||
              got.code_total      !== want.code_total) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"[%0t] result mismatch: exp alert=%0d cnt=%0d span=%0d burst=%0d",
                        " bcnt=%0d total=%0d / got alert=%0d cnt=%0d span=%0d burst=%0d",
                        " bcnt=%0d total=%0d"}, $realtime,
                       want.same_code_alert, want.same_code_count, want.same_code_span,
                       want.burst_alert, want.burst_count, want.code_total,
                       got.same_code_alert, got.same_code_count, got.same_code_span,
                       got.burst_alert, got.burst_count, got.code_total);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the request rate burst detector: directed requests around
// frame wrap and frame zero, then clustered requests from a set of busy
// identifiers mixed with fresh identifiers that force evictions, under
// several register settings and random stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rrbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i;
  logic                rst_ni;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int                  fail_count;
  int                  pending;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles;
  logic [TimeW-1:0] frame_now;
  logic [CodeW-1:0] busy_codes [8];

  request_rate_burst_detector dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  rrbd_checker u_checker (
    .clk_i, .rst_ni,
    .req_tdata_i (s_axis_tdata), .req_tvalid_i (s_axis_tvalid),
    .req_tready_i(s_axis_tready),
    .res_tdata_i (m_axis_tdata), .res_tvalid_i (m_axis_tvalid),
    .res_tready_i(m_axis_tready),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when requested
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready = 1'b0;
    else if (hold_cycles != 0) begin
      m_axis_tready = 1'b0;
      hold_cycles--;
    end else m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Offers one request and waits for its transfer.
  task automatic send_request(logic [CodeW-1:0] code, logic [TimeW-1:0] frame);
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk_i);
    s_axis_tdata  = {frame, code};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_index_i = idx;
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drains outstanding results, lets the block settle, then loads registers.
  task automatic load_regs(logic [WinW-1:0] id_win, logic [IdThrW-1:0] id_thr,
                           logic [WinW-1:0] holdoff, logic [WinW-1:0] b_win,
                           logic [BurstThrW-1:0] b_thr);
    wait (pending == 0);
    repeat (250) @(negedge clk_i);
    write_reg(CFG_ID_WINDOW, id_win);
    write_reg(CFG_ID_THRESHOLD, CfgDataW'(id_thr));
    write_reg(CFG_ALERT_HOLDOFF, holdoff);
    write_reg(CFG_BURST_WINDOW, b_win);
    write_reg(CFG_BURST_THRESHOLD, CfgDataW'(b_thr));
  endtask

  // Mostly busy identifiers at clustered frames; fresh codes force evictions.
  task automatic random_requests(int count);
    int unsigned pick;
    logic [CodeW-1:0] code;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        code = busy_codes[$urandom_range(0, 7)];
        frame_now += $urandom_range(0, 12);
      end else if (pick < 88) begin
        code = CodeW'($urandom);
        frame_now += $urandom_range(0, 30);
      end else if (pick < 94) begin
        code = busy_codes[$urandom_range(0, 7)];
        frame_now += $urandom_range(300, 2000);
      end else if (pick < 97) begin
        code = CodeW'($urandom);
        frame_now = $urandom;
      end else begin
        code = busy_codes[$urandom_range(0, 7)];
        frame_now = 32'hFFFF_FFFF - $urandom_range(0, 40);
      end
      send_request(code, frame_now);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_ID_WINDOW;
    cfg_data_i    = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 0;
    for (int i = 0; i < 8; i++) busy_codes[i] = CodeW'($urandom);
    busy_codes[0] = 16'h0000;
    busy_codes[1] = 16'hFFFF;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes, frame wrap, burst alert just before the frame wrap
    send_request(16'h0000, 32'h0000_0000);
    send_request(16'hFFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++)
      send_request((i % 2) ? 16'h5A00 : 16'h00A5, 32'hFFFF_FFF5 + i);
    for (int i = 1; i <= 3; i++) send_request(16'h5A00, TimeW'(i));
    send_request(16'hAAAA, 32'h8000_0000);
    send_request(16'h5555, 32'h7FFF_FFFF);
    send_request(16'hFFFF, 32'h8000_0190);

    // extremes: widest windows, zero thresholds and holdoff
    load_regs(16'hFFFF, 4'd0, 16'd0, 16'hFFFF, 7'd0);
    frame_now = 32'h0000_1000;
    random_requests(150);
    // extremes: zero windows, largest thresholds and holdoff
    load_regs(16'd0, 4'hF, 16'hFFFF, 16'd0, 7'h7F);
    random_requests(150);
    load_regs(16'd8, 4'd1, 16'd1, 16'd1, 7'd1);
    random_requests(100);

    // three idling regimes: two with random in-range settings, one with the reset defaults
    load_regs(16'($urandom_range(20, 600)), 4'($urandom_range(1, 8)),
              16'($urandom_range(0, 800)), 16'($urandom_range(5, 80)),
              7'($urandom_range(1, 64)));
    send_idle_pct = 36;
    recv_idle_pct = 63;
    random_requests(330);
    load_regs(16'($urandom_range(20, 600)), 4'($urandom_range(1, 8)),
              16'($urandom_range(0, 800)), 16'($urandom_range(5, 80)),
              7'($urandom_range(1, 64)));
    send_idle_pct = 63;
    recv_idle_pct = 36;
    random_requests(330);
    load_regs(RST_ID_WINDOW, RST_ID_THRESHOLD, RST_ALERT_HOLDOFF,
              RST_BURST_WINDOW, RST_BURST_THRESHOLD);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 3000;   // result side stalls long enough to back up the input
    random_requests(330);

    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
